>>> design/lcka_pkg.sv
// ============================================================================
// lcka_pkg: shared types and constants for the linear color key alpha block
// Field widths, derived arithmetic widths, register indexes and the control
// bundle that travels down the pipeline next to each item.
// ============================================================================
package lcka_pkg;

    // Pixel and key channel width
    localparam int unsigned CHAN_W  = 8;
    // Configuration field widths
    localparam int unsigned TOL_W   = 12;
    localparam int unsigned SOFT_W  = 11;
    // Manhattan distance (0..765) and the distance in Q10.4
    localparam int unsigned DIST_W  = 10;
    localparam int unsigned DQ4_W   = DIST_W + 4;
    // Signed compare width covering distance, tolerance +/- softness
    localparam int unsigned CMP_W   = 15;
    // Ramp numerator (at most 2 * softness), divisor and scaled numerator
    localparam int unsigned NUM_W   = SOFT_W + 1;
    localparam int unsigned DEN_W   = SOFT_W + 1;
    localparam int unsigned PROD_W  = NUM_W + 8;
    // Alpha and quotient width; one divider step per quotient bit
    localparam int unsigned ALPHA_W = 8;
    localparam int unsigned DIV_STEPS = ALPHA_W;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_RED   = 3'd0,
        CFG_KEY_GREEN = 3'd1,
        CFG_KEY_BLUE  = 3'd2,
        CFG_TOLERANCE = 3'd3,
        CFG_SOFTNESS  = 3'd4
    } lcka_cfg_idx_t;

    // Register reset values
    localparam logic [CHAN_W-1:0] KEY_RED_RST   = 8'd0;
    localparam logic [CHAN_W-1:0] KEY_GREEN_RST = 8'd255;
    localparam logic [CHAN_W-1:0] KEY_BLUE_RST  = 8'd0;
    localparam logic [TOL_W-1:0]  TOL_RST       = 12'd480;
    localparam logic [SOFT_W-1:0] SOFT_RST      = 11'd160;

    localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'd255;

    // Per-item control carried alongside the data
    typedef struct packed {
        logic valid;
        logic zero;   // distance at or below the lower bound
        logic full;   // beyond the ramp, or no ramp at all
    } lcka_ctrl_t;

endpackage

>>> design/linear_color_key_alpha.sv
// ============================================================================
// linear_color_key_alpha: chroma key alpha from Manhattan color distance
// Configuration registers, front pipeline, divider pipeline, output select.
// ============================================================================
// Takes one RGB pixel per clock and returns one alpha per pixel, in order,
// after four stages for distance, bounds and numerator,
// eight restoring divider stages (one quotient bit each) and the output
// register. busy is always low and done strobes for one cycle per item;
// results cannot be held off, so a new pixel may be started every cycle.
// Configuration writes are always taken (cfg_ready high) and must happen
// while no pixel is in flight.
module linear_color_key_alpha
    import lcka_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [CHAN_W-1:0]     red_in,
    input  logic [CHAN_W-1:0]     green_in,
    input  logic [CHAN_W-1:0]     blue_in,
    output logic                  done,
    output logic [ALPHA_W-1:0]    alpha_out,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CHAN_W-1:0]  key_red_reg, key_green_reg, key_blue_reg;
    logic [TOL_W-1:0]   tol_reg;
    logic [SOFT_W-1:0]  soft_reg;
    logic [DEN_W-1:0]   den;

    lcka_ctrl_t         ctrl_chain [DIV_STEPS+1];
    logic [PROD_W-1:0]  rem_chain  [DIV_STEPS+1];
    logic [ALPHA_W-1:0] quo_chain  [DIV_STEPS+1];

    lcka_ctrl_t         last_ctrl;
    logic               done_reg;
    logic [ALPHA_W-1:0] alpha_next, alpha_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_red_reg   <= KEY_RED_RST;
            key_green_reg <= KEY_GREEN_RST;
            key_blue_reg  <= KEY_BLUE_RST;
            tol_reg       <= TOL_RST;
            soft_reg      <= SOFT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_KEY_RED:   key_red_reg   <= cfg_data[CHAN_W-1:0];
                CFG_KEY_GREEN: key_green_reg <= cfg_data[CHAN_W-1:0];
                CFG_KEY_BLUE:  key_blue_reg  <= cfg_data[CHAN_W-1:0];
                CFG_TOLERANCE: tol_reg       <= cfg_data[TOL_W-1:0];
                CFG_SOFTNESS:  soft_reg      <= cfg_data[SOFT_W-1:0];
                default: ;
            endcase
        end
    end

    // Ramp width: twice the softness
    assign den = {soft_reg, 1'b0};

    // Distance, classification, scaled numerator
    lcka_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start && !busy),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .key_red      (key_red_reg),
        .key_green    (key_green_reg),
        .key_blue     (key_blue_reg),
        .tolerance_q4 (tol_reg),
        .softness_q4  (soft_reg),
        .ctrl_out     (ctrl_chain[0]),
        .prod_out     (rem_chain[0])
    );

    assign quo_chain[0] = '0;

    // Restoring divider, quotient msb first; numerator < 256 * den on the ramp
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        lcka_div_step #(
            .SHIFT (DIV_STEPS - 1 - i)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl_in  (ctrl_chain[i]),
            .rem_in   (rem_chain[i]),
            .quo_in   (quo_chain[i]),
            .den      (den),
            .ctrl_out (ctrl_chain[i+1]),
            .rem_out  (rem_chain[i+1]),
            .quo_out  (quo_chain[i+1])
        );
    end

    // Output select
    assign last_ctrl = ctrl_chain[DIV_STEPS];

    always_comb
    begin
        if (last_ctrl.zero)
            alpha_next = '0;
        else if (last_ctrl.full)
            alpha_next = ALPHA_MAX;
        else
            alpha_next = quo_chain[DIV_STEPS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= last_ctrl.valid;
    end

    always_ff @(posedge clk)
    begin
        alpha_reg <= alpha_next;
    end

    assign done      = done_reg;
    assign alpha_out = alpha_reg;

endmodule

>>> design/lcka_front.sv
// ============================================================================
// lcka_front: distance, classification and ramp numerator
// Four register stages: channel differences, distance sum, compare against
// the ramp bounds, and the numerator scaled by 255.
// ============================================================================
module lcka_front
    import lcka_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [CHAN_W-1:0]   red_in,
    input  logic [CHAN_W-1:0]   green_in,
    input  logic [CHAN_W-1:0]   blue_in,
    input  logic [CHAN_W-1:0]   key_red,
    input  logic [CHAN_W-1:0]   key_green,
    input  logic [CHAN_W-1:0]   key_blue,
    input  logic [TOL_W-1:0]    tolerance_q4,
    input  logic [SOFT_W-1:0]   softness_q4,
    output lcka_ctrl_t          ctrl_out,
    output logic [PROD_W-1:0]   prod_out
);

    logic [CHAN_W-1:0] dr_next, dg_next, db_next;
    logic [CHAN_W-1:0] dr_reg, dg_reg, db_reg;
    logic              v1_reg, v2_reg;
    logic [DQ4_W-1:0]  dq4_next, dq4_reg;
    logic signed [CMP_W-1:0] d_s, lo_s, hi_s, num_s;
    lcka_ctrl_t        c3_next, c3_reg, c4_reg;
    logic [NUM_W-1:0]  num_next, num_reg;
    logic [PROD_W-1:0] prod_next, prod_reg;

    // Stage 1: absolute channel differences
    always_comb
    begin
        dr_next = (red_in   > key_red)   ? red_in   - key_red   : key_red   - red_in;
        dg_next = (green_in > key_green) ? green_in - key_green : key_green - green_in;
        db_next = (blue_in  > key_blue)  ? blue_in  - key_blue  : key_blue  - blue_in;
    end

    // Stage 2: Manhattan distance, moved to Q10.4
    assign dq4_next = {DIST_W'(dr_reg) + DIST_W'(dg_reg) + DIST_W'(db_reg), 4'b0000};

    // Stage 3: compare against tolerance -/+ softness, form ramp numerator
    always_comb
    begin
        d_s   = signed'(CMP_W'(dq4_reg));
        lo_s  = signed'(CMP_W'(tolerance_q4)) - signed'(CMP_W'(softness_q4));
        hi_s  = signed'(CMP_W'(tolerance_q4)) + signed'(CMP_W'(softness_q4));
        num_s = d_s - lo_s;
        c3_next.valid = v2_reg;
        c3_next.zero  = (d_s <= lo_s);
        c3_next.full  = !(d_s <= lo_s) && ((softness_q4 == '0) || (d_s > hi_s));
        // only meaningful on the ramp, where it is at most 2 * softness
        num_next = num_s[NUM_W-1:0];
    end

    // Stage 4: numerator times 255
    assign prod_next = {num_reg, 8'b0} - PROD_W'(num_reg);

    // Valid bits and per-item control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            c3_reg <= '0;
            c4_reg <= '0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            c3_reg <= c3_next;
            c4_reg <= c3_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        dr_reg   <= dr_next;
        dg_reg   <= dg_next;
        db_reg   <= db_next;
        dq4_reg  <= dq4_next;
        num_reg  <= num_next;
        prod_reg <= prod_next;
    end

    assign ctrl_out = c4_reg;
    assign prod_out = prod_reg;

endmodule

>>> design/lcka_div_step.sv
// ============================================================================
// lcka_div_step: one registered step of the restoring ramp divider
// Tries to subtract the divisor shifted by SHIFT and shifts the result bit
// into the quotient, most significant bit first.
// ============================================================================
module lcka_div_step
    import lcka_pkg::*;
#(
    parameter int unsigned SHIFT = 7
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  lcka_ctrl_t          ctrl_in,
    input  logic [PROD_W-1:0]   rem_in,
    input  logic [ALPHA_W-1:0]  quo_in,
    input  logic [DEN_W-1:0]    den,
    output lcka_ctrl_t          ctrl_out,
    output logic [PROD_W-1:0]   rem_out,
    output logic [ALPHA_W-1:0]  quo_out
);

    logic [PROD_W-1:0]  trial;
    logic               fits;
    logic [PROD_W-1:0]  rem_next, rem_reg;
    logic [ALPHA_W-1:0] quo_next, quo_reg;
    lcka_ctrl_t         ctrl_reg;

    // Compare and conditional subtract
    always_comb
    begin
        trial    = PROD_W'(den) << SHIFT;
        fits     = (rem_in >= trial);
        rem_next = fits ? rem_in - trial : rem_in;
        quo_next = {quo_in[ALPHA_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else
            ctrl_reg <= ctrl_in;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign ctrl_out = ctrl_reg;
    assign rem_out  = rem_reg;
    assign quo_out  = quo_reg;

endmodule
